// File: sv/bf_exec_pkg.sv
// Package for the Brainfuck execute unit: payload types, command codes and defaults.
`timescale 1ns / 1ps
package bf_exec_pkg;

  localparam int TAPE_CELLS_DEF = 4096;
  localparam int START_CELL_DEF = 1000;
  localparam int LOOP_DEPTH_DEF = 256;
  localparam int ADDR_BITS_DEF  = 16;

  localparam logic [7:0] CMD_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] CMD_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] CMD_INC   = 8'h2B;  // '+'
  localparam logic [7:0] CMD_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] CMD_OUT   = 8'h2E;  // '.'
  localparam logic [7:0] CMD_IN    = 8'h2C;  // ','
  localparam logic [7:0] CMD_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CMD_CLOSE = 8'h5D;  // ']'

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [15:0] SKIP_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  instr_byte;
    logic [15:0] next_addr;
    logic [7:0]  in_byte;
  } bf_in_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        jump_valid;
    logic [15:0] jump_addr;
    logic [1:0]  status;
  } bf_out_t;

endpackage

// File: sv/brainfuck_execute_unit_top.sv
// Brainfuck execute unit: tape and loop stack memories with a two-step read-modify-write.
//
// One input item carries a program byte, the address after it and an input
// character for ','. Every accepted item yields exactly one result item on the
// out_ channel: the emitted cell for '.', a jump request for ']' on a nonzero
// cell, and a status code (ok, halt on empty stack, push dropped).
// Both channels use valid/stall; an item moves when valid is high and stall low.
// An accepted item waits in the execute stage until the output register is free,
// where its result is then registered. A new item is taken only after the last
// one leaves the execute stage, set by the tape read-modify-write (read at accept,
// write back on execute) and the pointer, skip and stack state the next item needs.
// After reset the tape is swept to zero, one cell per cycle, over all TAPE_CELLS
// cells (4096 by default); in_stall stays high during the sweep.
// When the receiver stalls, the result holds in the output register; one more
// item may be accepted and waits in the execute stage until the output frees.
`timescale 1ns / 1ps
module brainfuck_execute_unit_top #(
  parameter int TAPE_CELLS = bf_exec_pkg::TAPE_CELLS_DEF,
  parameter int START_CELL = bf_exec_pkg::START_CELL_DEF,
  parameter int LOOP_DEPTH = bf_exec_pkg::LOOP_DEPTH_DEF,
  parameter int ADDR_BITS  = bf_exec_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bf_exec_pkg::bf_in_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bf_exec_pkg::bf_out_t out_data
);
  import bf_exec_pkg::*;

  localparam int DPW  = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
  localparam int IDXW = $clog2(LOOP_DEPTH);
  localparam int CNTW = $clog2(LOOP_DEPTH + 1);
  localparam int EXTW = ADDR_BITS + 16;
  localparam logic [DPW-1:0]  DP_LAST  = DPW'(TAPE_CELLS - 1);
  localparam logic [DPW-1:0]  DP_START = DPW'(START_CELL % TAPE_CELLS);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(LOOP_DEPTH);

  // memories
  logic [7:0]           tape_mem [TAPE_CELLS];
  logic [ADDR_BITS-1:0] stack_mem [LOOP_DEPTH];
  logic [7:0]           tape_q;
  logic [ADDR_BITS-1:0] stack_q;

  // control state
  logic                 clearing_r;
  logic [DPW-1:0]       clr_addr_r;
  logic [DPW-1:0]       dp_r, dp_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [15:0]          skip_r, skip_nxt;
  logic                 s1_valid_r;
  logic                 out_valid_r;

  // execute stage payload
  logic [7:0]           s1_cmd_r;
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic [7:0]           s1_inb_r;
  bf_out_t              out_data_r;
  bf_out_t              res;

  logic                 in_fire, s1_fire;
  logic                 tape_we, push_we;
  logic [7:0]           tape_wdata;
  logic [DPW-1:0]       tape_waddr;
  logic [EXTW-1:0]      addr_ext, top_ext;
  logic [IDXW-1:0]      top_idx;

  assign in_stall  = clearing_r || s1_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign addr_ext = EXTW'(in_data.next_addr);
  assign top_ext  = EXTW'(stack_q);
  assign top_idx  = IDXW'(cnt_r - CNTW'(1));

  // execute: read data from the accept edge is in tape_q / stack_q
  always_comb begin
    dp_nxt     = dp_r;
    cnt_nxt    = cnt_r;
    skip_nxt   = skip_r;
    tape_we    = 1'b0;
    tape_wdata = tape_q;
    push_we    = 1'b0;
    res        = '0;
    if (skip_r != 16'd0) begin
      if (s1_cmd_r == CMD_OPEN) begin
        if (skip_r != SKIP_MAX) begin
          skip_nxt = skip_r + 16'd1;
        end
      end else if (s1_cmd_r == CMD_CLOSE) begin
        skip_nxt = skip_r - 16'd1;
      end
    end else begin
      case (s1_cmd_r)
        CMD_RIGHT: dp_nxt = (dp_r == DP_LAST) ? '0 : dp_r + DPW'(1);
        CMD_LEFT:  dp_nxt = (dp_r == '0) ? DP_LAST : dp_r - DPW'(1);
        CMD_INC: begin
          tape_we    = 1'b1;
          tape_wdata = tape_q + 8'd1;
        end
        CMD_DEC: begin
          tape_we    = 1'b1;
          tape_wdata = tape_q - 8'd1;
        end
        CMD_OUT: begin
          res.out_valid = 1'b1;
          res.out_byte  = tape_q;
        end
        CMD_IN: begin
          tape_we    = 1'b1;
          tape_wdata = s1_inb_r;
        end
        CMD_OPEN: begin
          if (tape_q != 8'd0) begin
            if (cnt_r < CNT_FULL) begin
              push_we = 1'b1;
              cnt_nxt = cnt_r + CNTW'(1);
            end else begin
              res.status = ST_FULL;
            end
          end else begin
            skip_nxt = 16'd1;
          end
        end
        CMD_CLOSE: begin
          if (tape_q != 8'd0) begin
            if (cnt_r != '0) begin
              res.jump_valid = 1'b1;
              res.jump_addr  = top_ext[15:0];
            end else begin
              res.status = ST_HALT;
            end
          end else if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNTW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // tape write port is shared with the post-reset sweep
  assign tape_waddr = clearing_r ? clr_addr_r : dp_r;

  always_ff @(posedge clk) begin
    if (clearing_r || (s1_fire && tape_we)) begin
      tape_mem[tape_waddr] <= clearing_r ? 8'd0 : tape_wdata;
    end
    if (in_fire) begin
      tape_q <= tape_mem[dp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && push_we) begin
      stack_mem[cnt_r[IDXW-1:0]] <= s1_addr_r;
    end
    if (in_fire) begin
      stack_q <= stack_mem[top_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      dp_r        <= DP_START;
      cnt_r       <= '0;
      skip_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + DPW'(1);
        if (clr_addr_r == DP_LAST) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        dp_r        <= dp_nxt;
        cnt_r       <= cnt_nxt;
        skip_r      <= skip_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_data.instr_byte;
      s1_addr_r <= addr_ext[ADDR_BITS-1:0];
      s1_inb_r  <= in_data.in_byte;
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

endmodule

// File: bench/tb_brainfuck_execute_unit_top.sv
// Testbench for the Brainfuck execute unit: directed and random programs checked by a scoreboard.
`timescale 1ns / 1ps
module tb_brainfuck_execute_unit_top;
  import bf_exec_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_OFF_CYCLES = 300;

  // Shadow of the tape, pointer, loop stack and skip depth; holds expected results.
  class bf_tape_tracker;
    logic [7:0]  tape_img [TAPE_CELLS_DEF];
    logic [15:0] ret_addrs [LOOP_DEPTH_DEF];
    int unsigned ptr;
    int unsigned ret_count;
    logic [15:0] skip_level;
    bf_out_t     expected_results [$];
    int unsigned fail_count;

    function new();
      foreach (tape_img[i]) tape_img[i] = 8'h00;
      ptr = START_CELL_DEF % TAPE_CELLS_DEF;
      ret_count = 0;
      skip_level = 16'h0000;
      fail_count = 0;
    endfunction

    function void note_instr(bf_in_t item);
      bf_out_t res;
      logic [7:0] cur_val;
      res = '0;
      cur_val = tape_img[ptr];
      if (skip_level != 16'h0000) begin
        if (item.instr_byte == CMD_OPEN) begin
          if (skip_level != SKIP_MAX) skip_level++;
        end else if (item.instr_byte == CMD_CLOSE) begin
          skip_level--;
        end
      end else begin
        case (item.instr_byte)
          CMD_RIGHT: ptr = (ptr + 1) % TAPE_CELLS_DEF;
          CMD_LEFT:  ptr = (ptr == 0) ? TAPE_CELLS_DEF - 1 : ptr - 1;
          CMD_INC:   tape_img[ptr] = cur_val + 8'd1;
          CMD_DEC:   tape_img[ptr] = cur_val - 8'd1;
          CMD_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte = cur_val;
          end
          CMD_IN:    tape_img[ptr] = item.in_byte;
          CMD_OPEN: begin
            if (cur_val != 8'h00) begin
              if (ret_count < LOOP_DEPTH_DEF) begin
                ret_addrs[ret_count] = item.next_addr;
                ret_count++;
              end else begin
                res.status = ST_FULL;
              end
            end else begin
              skip_level = 16'h0001;
            end
          end
          CMD_CLOSE: begin
            if (cur_val != 8'h00) begin
              if (ret_count != 0) begin
                res.jump_valid = 1'b1;
                res.jump_addr = ret_addrs[ret_count - 1];
              end else begin
                res.status = ST_HALT;
              end
            end else if (ret_count != 0) begin
              ret_count--;
            end
          end
          default: ;
        endcase
      end
      expected_results.push_back(res);
    endfunction

    function void flag_error(string what, bf_out_t want, bf_out_t got);
      fail_count++;
      if (fail_count <= 10) begin
        $display("%s: expected ov=%0b ob=%02h jv=%0b ja=%04h st=%0d",
                 what, want.out_valid, want.out_byte, want.jump_valid, want.jump_addr,
                 want.status);
        $display("  got ov=%0b ob=%02h jv=%0b ja=%04h st=%0d",
                 got.out_valid, got.out_byte, got.jump_valid, got.jump_addr, got.status);
      end
    endfunction

    function void check_result(bf_out_t got);
      bf_out_t want;
      if (expected_results.size() == 0) begin
        flag_error("result with nothing pending", '0, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
          got.jump_valid !== want.jump_valid || got.jump_addr !== want.jump_addr ||
          got.status !== want.status)
        flag_error($sformatf("result mismatch at %0t", $time), want, got);
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  bf_in_t  in_data;
  logic    out_valid;
  logic    out_stall;
  bf_out_t out_data;

  bit tx_idles = 1'b1;
  bit rx_idles = 1'b1;
  bit hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  bf_tape_tracker sb = new();

  brainfuck_execute_unit_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Note accepted items before checking results of the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_instr(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= rx_idles && ($urandom_range(99) < 23);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic [7:0] cmd, input logic [15:0] addr,
                           input logic [7:0] data);
    bf_in_t item;
    item.instr_byte = cmd;
    item.next_addr = addr;
    item.in_byte = data;
    while (tx_idles && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_plain(input logic [7:0] cmd);
    send_item(cmd, 16'($urandom_range(65535)), 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned item_no;
    int unsigned pick;
    logic [7:0] cmd;
    logic [7:0] data;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: wraps, skip nesting, empty-stack cases, push and jump extremes.
    send_item(CMD_OUT, 16'h0000, 8'h00);
    send_item(CMD_DEC, 16'hFFFF, 8'hFF);
    send_item(CMD_OUT, 16'h0001, 8'h00);
    send_item(CMD_INC, 16'h0002, 8'h00);
    send_item(CMD_IN, 16'h0003, 8'hFF);
    send_item(CMD_OUT, 16'h0004, 8'h00);
    send_item(CMD_IN, 16'h0005, 8'h00);
    send_item(CMD_CLOSE, 16'h0006, 8'h00);
    send_item(CMD_OPEN, 16'hFFFF, 8'h00);
    send_item(8'h00, 16'h0008, 8'hFF);
    send_item(CMD_OPEN, 16'h0009, 8'h00);
    send_item(CMD_OUT, 16'h000A, 8'h00);
    send_item(CMD_CLOSE, 16'h000B, 8'h00);
    send_item(CMD_CLOSE, 16'h000C, 8'h00);
    send_item(CMD_INC, 16'h000D, 8'h00);
    send_item(CMD_CLOSE, 16'h000E, 8'h00);
    send_item(CMD_OPEN, 16'hFFFF, 8'h00);
    send_item(CMD_OPEN, 16'h0000, 8'h00);
    send_item(CMD_CLOSE, 16'h0011, 8'h00);
    send_item(CMD_RIGHT, 16'h0012, 8'h00);
    send_item(CMD_CLOSE, 16'h0013, 8'h00);
    send_item(CMD_LEFT, 16'h0014, 8'h00);
    send_item(CMD_CLOSE, 16'h0015, 8'h00);
    send_item(8'hFF, 16'h0016, 8'h00);

    // Overfill the loop stack, jump from the top, then drain it past empty.
    send_item(CMD_IN, 16'h1234, 8'h5A);
    repeat (LOOP_DEPTH_DEF + 2) send_plain(CMD_OPEN);
    send_plain(CMD_CLOSE);
    send_item(CMD_IN, 16'h4321, 8'h00);
    repeat (LOOP_DEPTH_DEF + 4) send_plain(CMD_CLOSE);

    // Random programs; brackets are frequent so loops and skips nest.
    item_no = 0;
    while (item_no < RANDOM_ITEMS) begin
      item_no++;
      if (item_no == 300) hold_off_req = 1'b1;
      tx_idles = !(item_no >= 500 && item_no < 700);
      rx_idles = tx_idles;
      pick = $urandom_range(99);
      if (pick < 15) cmd = CMD_INC;
      else if (pick < 25) cmd = CMD_DEC;
      else if (pick < 37) cmd = CMD_RIGHT;
      else if (pick < 49) cmd = CMD_LEFT;
      else if (pick < 59) cmd = CMD_OUT;
      else if (pick < 67) cmd = CMD_IN;
      else if (pick < 79) cmd = CMD_OPEN;
      else if (pick < 91) cmd = CMD_CLOSE;
      else cmd = 8'($urandom_range(255));
      data = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
      send_item(cmd, 16'($urandom_range(65535)), data);
    end
    in_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
